// File: hdl/itds_pkg.sv
// itds_pkg: shared types, register indexes, reset values and the symbol lookup
// for the integer to digit string block
// depends on nothing
package itds_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_0_3 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_4_7 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_8_11 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYM_12_15 = 3'd4;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd3;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CFG_DATA_W-1:0] SYM_0_3_RESET = 32'h3332_3130;
  localparam logic [CFG_DATA_W-1:0] SYM_4_7_RESET = 32'h3736_3534;
  localparam logic [CFG_DATA_W-1:0] SYM_8_11_RESET = 32'h6261_3938;
  localparam logic [CFG_DATA_W-1:0] SYM_12_15_RESET = 32'h6665_6463;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  typedef struct packed {
    logic [RADIX_W-1:0]             base;
    logic [3:0][CFG_DATA_W-1:0]     symbols;
  } cfg_t;

  function automatic logic [CHAR_W-1:0] symbol_of(input logic [3:0][CFG_DATA_W-1:0] syms,
                                                  input logic [DIGIT_W-1:0] d);
    logic [CFG_DATA_W-1:0] word;
    word = syms[d[3:2]];
    return word[{d[1:0], 3'b000} +: CHAR_W];
  endfunction

endpackage

// File: hdl/itds_cfg_regs.sv
// itds_cfg_regs: radix and symbol table registers, radix clamped to 3..16
// depends on itds_pkg
module itds_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [itds_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [itds_pkg::CFG_DATA_W-1:0]   wr_data,
  output itds_pkg::cfg_t                    cfg_o
);
  import itds_pkg::*;

  logic [RADIX_W-1:0]         radix_r;
  logic [3:0][CFG_DATA_W-1:0] sym_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
      sym_r[0] <= SYM_0_3_RESET;
      sym_r[1] <= SYM_4_7_RESET;
      sym_r[2] <= SYM_8_11_RESET;
      sym_r[3] <= SYM_12_15_RESET;
    end else if (wr_en) begin
      case (wr_index)
        CFG_RADIX:     radix_r <= wr_data[RADIX_W-1:0];
        CFG_SYM_0_3:   sym_r[0] <= wr_data;
        CFG_SYM_4_7:   sym_r[1] <= wr_data;
        CFG_SYM_8_11:  sym_r[2] <= wr_data;
        CFG_SYM_12_15: sym_r[3] <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_o.symbols = sym_r;
    if (radix_r < RADIX_MIN) begin
      cfg_o.base = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      cfg_o.base = RADIX_MAX;
    end else begin
      cfg_o.base = radix_r;
    end
  end

endmodule

// File: hdl/itds_div_step.sv
// itds_div_step: shared long-division unit, one dividend byte per use
// eight restoring compare-subtract steps on a 5-bit partial remainder
// depends on itds_pkg
module itds_div_step (
  input  logic [itds_pkg::RADIX_W-1:0] base,
  input  logic [itds_pkg::DIGIT_W-1:0] rem_in,
  input  logic [7:0]                   byte_in,
  output logic [7:0]                   quot_out,
  output logic [itds_pkg::DIGIT_W-1:0] rem_out
);
  import itds_pkg::*;

  always_comb begin
    logic [RADIX_W-1:0] t;
    t = {1'b0, rem_in};
    quot_out = '0;
    for (int i = 7; i >= 0; i--) begin
      t = {t[RADIX_W-2:0], byte_in[i]};
      if (t >= base) begin
        t = t - base;
        quot_out[i] = 1'b1;
      end
    end
    rem_out = t[DIGIT_W-1:0];
  end

endmodule

// File: hdl/integer_to_digit_string.sv
// integer_to_digit_string: top level, sequencer, digit store and output register
// depends on itds_pkg, itds_cfg_regs, itds_div_step
//
// Converts one 64-bit value at a time to its digits in the configured base
// (3..16), most significant first, one character per output transfer, with a
// leading minus for a negative signed value and tlast on the final character.
// in_tready is high only while the block is idle. Each digit is produced by
// running the 8-bit shared divide unit over the significant bytes of the
// running quotient, one byte per cycle, from its highest nonzero byte (1 to 8
// bytes) down to byte 0. After a setup state and the divide pass, a fetch
// state reads the digit store (a negative value shows its minus instead),
// then each character takes a load of the output register and a show state
// that holds it until the output accepts it. Configuration writes
// are always taken and must only arrive while the block is idle.
module integer_to_digit_string #(
  parameter int unsigned DIGIT_SLOTS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: number_bits[63:0]
  input  logic [63:0]                       in_tdata,
  // tuser: mode
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: out_char[7:0]
  output logic [7:0]                        out_tdata,
  output logic                              out_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [itds_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [itds_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import itds_pkg::*;

  localparam int unsigned CW = $clog2(DIGIT_SLOTS + 1);
  localparam int unsigned AW = $clog2(DIGIT_SLOTS);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_PREP  = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_SIGN  = 7'b0001000,
    ST_FETCH = 7'b0010000,
    ST_LOAD  = 7'b0100000,
    ST_SHOW  = 7'b1000000
  } state_t;

  cfg_t cfg;

  state_t              state_r, state_nxt;
  logic [VALUE_W-1:0]  val_r, val_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic [2:0]          start_r, start_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic                topnz_r, topnz_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [7:0]          div_byte;
  logic [7:0]          div_quot;
  logic [DIGIT_W-1:0]  div_rem;
  logic                topnz_eff;
  logic [2:0]          top_byte;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [AW-1:0]       rd_addr;
  logic [DIGIT_W-1:0]  digit_mem [DIGIT_SLOTS];
  logic [DIGIT_W-1:0]  rd_data_r;

  assign cfg_ready = 1'b1;

  itds_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg_o    (cfg)
  );

  assign div_byte = val_r[{idx_r, 3'b000} +: 8];

  itds_div_step u_div (
    .base     (cfg.base),
    .rem_in   (rem_r),
    .byte_in  (div_byte),
    .quot_out (div_quot),
    .rem_out  (div_rem)
  );

  assign topnz_eff = (idx_r == start_r) ? (div_quot != 8'd0) : topnz_r;

  // highest nonzero byte of the working value
  always_comb begin
    top_byte = 3'd0;
    for (int b = 0; b < 8; b++) begin
      if (val_r[b*8 +: 8] != 8'd0) begin
        top_byte = 3'(b);
      end
    end
  end

  assign wr_en   = (state_r == ST_DIV) && (idx_r == 3'd0);
  assign wr_addr = cnt_r[AW-1:0];
  assign rd_addr = AW'(cnt_r - CW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      digit_mem[wr_addr] <= div_rem;
    end
    rd_data_r <= digit_mem[rd_addr];
  end

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    start_nxt     = start_r;
    rem_nxt       = rem_r;
    topnz_nxt     = topnz_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          neg_nxt = in_tuser && in_tdata[VALUE_W-1];
          val_nxt = (in_tuser && in_tdata[VALUE_W-1]) ? (64'd0 - in_tdata) : in_tdata;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        start_nxt = top_byte;
        idx_nxt   = top_byte;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        val_nxt[{idx_r, 3'b000} +: 8] = div_quot;
        if (idx_r == start_r) begin
          topnz_nxt = div_quot != 8'd0;
        end
        if (idx_r == 3'd0) begin
          cnt_nxt = cnt_r + CW'(1);
          rem_nxt = '0;
          if (!topnz_eff && (start_r == 3'd0)) begin
            // quotient is zero, all digits stored
            if (neg_r) begin
              out_valid_nxt = 1'b1;
              out_char_nxt  = MINUS_CHAR;
              out_last_nxt  = 1'b0;
              state_nxt     = ST_SIGN;
            end else begin
              state_nxt = ST_FETCH;
            end
          end else begin
            start_nxt = topnz_eff ? start_r : (start_r - 3'd1);
            idx_nxt   = topnz_eff ? start_r : (start_r - 3'd1);
          end
        end else begin
          idx_nxt = idx_r - 3'd1;
          rem_nxt = div_rem;
        end
      end
      ST_SIGN: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_LOAD;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = symbol_of(cfg.symbols, rd_data_r);
        out_last_nxt  = cnt_r == CW'(1);
        cnt_nxt       = cnt_r - CW'(1);
        state_nxt     = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = out_last_r ? ST_IDLE : ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      neg_r       <= 1'b0;
      val_r       <= '0;
      topnz_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      neg_r       <= neg_nxt;
      val_r       <= val_nxt;
      topnz_r     <= topnz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    start_r    <= start_nxt;
    rem_r      <= rem_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

endmodule
